// ----- hw/rtl/msp_pkg.sv -----
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants for the multi-stack slot pool
// stack count, pool depth, link encoding, payload structs and control codes
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int NUM_STACKS = 4;
  localparam int POOL_DEPTH = 8;

  localparam int SLOT_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int LINK_W     = $clog2(POOL_DEPTH + 1);
  localparam int HEAD_IDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int DATA_W     = 32;

  // null link: any value at or above the pool depth
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_DEPTH);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } msp_op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_BAD_STACK = 2'd3
  } msp_status_t;

  typedef struct packed {
    msp_op_t                   operation;
    logic [1:0]                stack_id;
    logic signed [DATA_W-1:0]  push_value;
  } msp_in_t;

  typedef struct packed {
    msp_status_t               status;
    logic signed [DATA_W-1:0]  popped_value;
  } msp_out_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } msp_state_t;

  typedef struct packed {
    logic ready;   // sequencer can take a new item
    logic accept;  // item transfer this cycle, link and data reads issued
    logic commit;  // write back links, heads and result this cycle
  } msp_ctrl_t;

endpackage

// ----- hw/rtl/multi_stack_shared_pool_unit.sv -----
// ----------------------------------------------------------------------------
// multi_stack_shared_pool_unit: several lifo stacks over one linked slot pool
// result: registered at the write-back step, which waits while the result register is held
// sequencing: a new item is taken only after the write-back of the last one, which follows
//   the registered read of the link and data memories and waits on the output stall
// reset: all stacks empty, free list runs slot 0 to the last slot in order
// ----------------------------------------------------------------------------
module multi_stack_shared_pool_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  msp_pkg::msp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output msp_pkg::msp_out_t out_data
);
  import msp_pkg::*;

  msp_ctrl_t ctrl;
  logic      out_free;

  // list heads: one per stack plus the free list
  logic [LINK_W-1:0] stack_head_r   [NUM_STACKS];
  logic [LINK_W-1:0] stack_head_nxt [NUM_STACKS];
  logic [LINK_W-1:0] free_head_r;
  logic [LINK_W-1:0] free_head_nxt;

  // item captured at the transfer
  msp_op_t            op_r;
  logic [1:0]         sid_r;
  logic [DATA_W-1:0]  val_r;
  logic [LINK_W-1:0]  slot_r;   // slot being pushed into or popped from
  logic [LINK_W-1:0]  head_r;   // top of the chosen stack at the transfer

  // transfer cycle read select
  logic [HEAD_IDX_W-1:0] in_idx;
  logic [HEAD_IDX_W-1:0] cur_idx;
  logic [LINK_W-1:0]     head_sel;
  logic [LINK_W-1:0]     rd_slot;
  logic                  rd_en;

  // memory ports
  logic [LINK_W-1:0] link_rdata;
  logic [LINK_W-1:0] link_wdata;
  logic              link_we;
  logic [DATA_W-1:0] data_rdata;
  logic              data_we;

  // write-back results
  logic        bad_stack;
  logic        slot_null;
  msp_out_t    result;
  logic        out_valid_r;
  logic        out_valid_nxt;
  msp_out_t    out_data_r;

  msp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  assign in_stall = !ctrl.ready;
  assign out_free = !out_valid_r || !out_stall;

  // read step: pop reads the stack top, push reads the free-list head
  assign in_idx   = HEAD_IDX_W'(in_data.stack_id);
  assign cur_idx  = HEAD_IDX_W'(sid_r);
  assign head_sel = stack_head_r[in_idx];
  assign rd_slot  = (in_data.operation == OP_POP) ? head_sel : free_head_r;
  assign rd_en    = ctrl.accept && (rd_slot < LINK_NULL);

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      op_r   <= in_data.operation;
      sid_r  <= in_data.stack_id;
      val_r  <= in_data.push_value;
      slot_r <= rd_slot;
      head_r <= head_sel;
    end
  end

  msp_link_store u_link (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (rd_en),
    .raddr (rd_slot[SLOT_W-1:0]),
    .we    (link_we),
    .waddr (slot_r[SLOT_W-1:0]),
    .wdata (link_wdata),
    .rdata (link_rdata)
  );

  msp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (POOL_DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (slot_r[SLOT_W-1:0]),
    .wdata (val_r),
    .re    (rd_en),
    .raddr (rd_slot[SLOT_W-1:0]),
    .rdata (data_rdata)
  );

  // write-back step: relink the slot and move the heads
  assign bad_stack = int'(sid_r) >= NUM_STACKS;
  assign slot_null = slot_r >= LINK_NULL;

  always_comb begin
    stack_head_nxt      = stack_head_r;
    free_head_nxt       = free_head_r;
    link_we             = 1'b0;
    link_wdata          = head_r;
    data_we             = 1'b0;
    result.status       = STAT_OK;
    result.popped_value = '0;
    priority if (bad_stack) begin
      result.status = STAT_BAD_STACK;
    end else if (op_r == OP_PUSH) begin
      if (slot_null) begin
        result.status = STAT_FULL;
      end else begin
        // free-list head becomes the new top, linked to the old top
        free_head_nxt           = link_rdata;
        link_we                 = ctrl.commit;
        link_wdata              = head_r;
        data_we                 = ctrl.commit;
        stack_head_nxt[cur_idx] = slot_r;
      end
    end else begin
      if (slot_null) begin
        result.status = STAT_EMPTY;
      end else begin
        // top slot goes back to the front of the free list
        stack_head_nxt[cur_idx] = link_rdata;
        result.popped_value     = data_rdata;
        link_we                 = ctrl.commit;
        link_wdata              = free_head_r;
        free_head_nxt           = slot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_head_r[i] <= LINK_NULL;
      end
      free_head_r <= '0;
    end else if (ctrl.commit) begin
      stack_head_r <= stack_head_nxt;
      free_head_r  <= free_head_nxt;
    end
  end

  // result register: holds until the downstream transfer
  assign out_valid_nxt = ctrl.commit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/msp_ram.sv -----
// ----------------------------------------------------------------------------
// msp_ram: generic single-write, single-read RAM
// one write port and one registered read port, no reset on contents
// ----------------------------------------------------------------------------
module msp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/msp_link_store.sv -----
// ----------------------------------------------------------------------------
// msp_link_store: slot link memory with per-entry valid bits
// an entry never written reads as its reset link, the next slot index
// ----------------------------------------------------------------------------
module msp_link_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      re,
  input  logic [msp_pkg::SLOT_W-1:0] raddr,
  input  logic                      we,
  input  logic [msp_pkg::SLOT_W-1:0] waddr,
  input  logic [msp_pkg::LINK_W-1:0] wdata,
  output logic [msp_pkg::LINK_W-1:0] rdata
);
  import msp_pkg::*;

  logic [POOL_DEPTH-1:0] valid_r;
  logic                  rd_valid_r;
  logic [SLOT_W-1:0]     rd_addr_r;
  logic [LINK_W-1:0]     ram_q;

  msp_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_valid_r <= valid_r[raddr];
      rd_addr_r  <= raddr;
    end
  end

  // reset link of slot i is i+1, the last slot reaching the null code
  assign rdata = rd_valid_r ? ram_q : (LINK_W'(rd_addr_r) + LINK_W'(1));

endmodule

// ----- hw/rtl/msp_ctrl.sv -----
// ----------------------------------------------------------------------------
// msp_ctrl: two-step sequencer of the slot pool
// read step at the transfer, write-back step once the result register is free
// ----------------------------------------------------------------------------
module msp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_free,
  output msp_pkg::msp_ctrl_t ctrl
);
  import msp_pkg::*;

  msp_state_t state_r;
  msp_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      S_IDLE: begin
        ctrl.ready  = 1'b1;
        ctrl.accept = in_valid;
      end
      S_EXEC: begin
        ctrl.commit = out_free;
      end
      default: ctrl = '0;
    endcase
  end

endmodule

// ----- tb/sv/multi_stack_shared_pool_unit_test.sv -----
// ----------------------------------------------------------------------------
// multi_stack_shared_pool_unit_test: self-checking bench for the slot pool
// drives push/pop transfers with random idling on both channels, tracks
// its own copy of the linked pool and compares every result in order
// ----------------------------------------------------------------------------
module multi_stack_shared_pool_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import msp_pkg::*;

  localparam int RANDOM_ITEMS = 1730;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_AT      = 300;   // long receiver hold-off starts here
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_LEN    = 600;   // transfers per idling phase
  localparam int TAIL_CYCLES  = 20;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  msp_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b1;
  msp_out_t out_data;

  multi_stack_shared_pool_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // items waiting to be offered, and results waiting to come back
  msp_in_t  pending_ops[$];
  msp_out_t expected_results[$];

  // shadow copy of the pool: values, links, stack tops and free list head
  logic signed [DATA_W-1:0] slot_val  [POOL_DEPTH];
  int                       slot_next [POOL_DEPTH];
  int                       stack_top [NUM_STACKS];
  int                       free_top;

  int n_accepted = 0;
  int n_results  = 0;
  int n_errors   = 0;
  int cycle_cnt  = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  // empty stacks, free list in slot order
  task automatic pool_reset();
    for (int i = 0; i < POOL_DEPTH; i++) begin
      slot_val[i]  = '0;
      slot_next[i] = i + 1;
    end
    for (int s = 0; s < NUM_STACKS; s++) stack_top[s] = POOL_DEPTH;
    free_top = 0;
  endtask

  // applies one push or pop to the shadow pool and gives the result it causes;
  // any link or head at or above the pool depth counts as null
  function automatic msp_out_t pool_apply(msp_in_t op);
    msp_out_t res;
    int       sid;
    int       slot;
    res.status       = STAT_OK;
    res.popped_value = '0;
    sid = op.stack_id;
    if (sid >= NUM_STACKS) begin
      res.status = STAT_BAD_STACK;
    end else if (op.operation == OP_PUSH) begin
      slot = free_top;
      if (slot >= POOL_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        free_top        = slot_next[slot];
        slot_val[slot]  = op.push_value;
        slot_next[slot] = stack_top[sid];
        stack_top[sid]  = slot;
      end
    end else begin
      slot = stack_top[sid];
      if (slot >= POOL_DEPTH) begin
        res.status = STAT_EMPTY;
      end else begin
        stack_top[sid]   = slot_next[slot];
        res.popped_value = slot_val[slot];
        slot_next[slot]  = free_top;
        free_top         = slot;
      end
    end
    return res;
  endfunction

  // idling rates: receiver-heavy, then sender-heavy, then none
  function automatic int send_idle_pct(int done);
    if (done < PHASE_LEN) return 29;
    if (done < 2 * PHASE_LEN) return 48;
    return 0;
  endfunction

  function automatic int recv_idle_pct(int done);
    if (done < PHASE_LEN) return 48;
    if (done < 2 * PHASE_LEN) return 29;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers the head of the pending queue, holds it while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    msp_out_t res;
    logic     offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = 1'b0;
      if (in_valid && !in_stall) begin
        // transfer done: predict and retire the item
        res = pool_apply(in_data);
        expected_results.push_back(res);
        status_seen[res.status]++;
        void'(pending_ops.pop_front());
        n_accepted <= n_accepted + 1;
      end
      if (in_valid && in_stall) begin
        offer = 1'b1;  // stalled payload stays put
      end else if (pending_ops.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct(n_accepted)) begin
        offer   = 1'b1;
        in_data <= pending_ops[0];
      end
      in_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver stall: random idling, plus one long hold-off so the block backs up
  // ---------------------------------------------------------------------------
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct(n_accepted));
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every result transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    msp_out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      n_results <= n_results + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%0d",
                 $time, out_data.status, out_data.popped_value);
        n_errors <= n_errors + 1;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data.status !== exp_res.status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d",
                   $time, exp_res.status, out_data.status);
          n_errors <= n_errors + 1;
        end
        if (out_data.popped_value !== exp_res.popped_value) begin
          $display("%0t: popped_value mismatch expected=%0d actual=%0d",
                   $time, exp_res.popped_value, out_data.popped_value);
          n_errors <= n_errors + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_op(msp_op_t kind, int sid, logic [DATA_W-1:0] val);
    msp_in_t op;
    op.operation  = kind;
    op.stack_id   = 2'(sid);
    op.push_value = val;
    pending_ops.push_back(op);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int               run_len;
    int               push_pct;
    logic [DATA_W-1:0] val;
    msp_op_t          kind;

    pool_reset();

    // directed: empty pop, extremes of the value, fill the pool, overflow,
    // drain in lifo order, then pops of empty stacks again
    // (a 2-bit stack id never reaches the bad-stack code with four stacks)
    queue_op(OP_POP,  0, 32'hFFFF_FFFF);
    queue_op(OP_PUSH, 0, 32'h7FFF_FFFF);
    queue_op(OP_PUSH, 3, 32'h8000_0000);
    queue_op(OP_PUSH, 1, 32'h0000_0000);
    queue_op(OP_PUSH, 2, 32'hFFFF_FFFF);
    for (int i = 1; i <= 4; i++) queue_op(OP_PUSH, 0, i);
    queue_op(OP_PUSH, 1, 32'h5A5A_A5A5);  // pool full
    for (int i = 0; i < 5; i++) queue_op(OP_POP, 0, 32'h0);
    queue_op(OP_POP,  0, 32'h0);           // stack 0 now empty
    queue_op(OP_POP,  3, 32'h0);
    queue_op(OP_POP,  1, 32'h0);
    queue_op(OP_POP,  2, 32'h0);
    queue_op(OP_POP,  2, 32'hA5A5_5A5A);   // empty again, value ignored
    queue_op(OP_PUSH, 2, 32'h1234_5678);
    queue_op(OP_POP,  2, 32'h0);

    // random: bursts leaning toward push or pop so the pool swings between
    // full and empty, with some even bursts as noise
    while (pending_ops.size() < RANDOM_ITEMS + 21) begin
      run_len = $urandom_range(1, 14);
      case ($urandom_range(2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < run_len; i++) begin
        kind = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
        case ($urandom_range(9))
          0:       val = 32'h7FFF_FFFF;
          1:       val = 32'h8000_0000;
          2:       val = ($urandom_range(1)) ? 32'h0 : 32'hFFFF_FFFF;
          default: val = $urandom;
        endcase
        queue_op(kind, $urandom_range(NUM_STACKS - 1), val);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d transfers in, %0d results out", n_accepted, n_results);
    $display("ok %0d, pool full %0d, stack empty %0d, bad stack %0d",
             status_seen[STAT_OK], status_seen[STAT_FULL],
             status_seen[STAT_EMPTY], status_seen[STAT_BAD_STACK]);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
